>>> hw/rtl/modular_exponentiation_macros.svh
// ----------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Property that must hold at every clock edge outside of reset.
`define MEXP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside of reset.
`define MEXP_NEVER(lbl, cond, msg) \
  `MEXP_ASSERT(lbl, !(cond), msg)

`endif

>>> hw/rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Field types and constants shared by the exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

  localparam int RES_W     = 30;
  localparam int EXP_W     = 32;
  localparam int EXP_WIDTH = 32;
  localparam int SCAN_BITS = (EXP_WIDTH < EXP_W) ? EXP_WIDTH : EXP_W;
  localparam int MUL_STEPS = RES_W;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);
  localparam int BIT_CNT_W = $clog2(SCAN_BITS + 1);
  localparam int WIDE_W    = RES_W + 2;

  typedef logic [RES_W-1:0]  residue_t;
  typedef logic [EXP_W-1:0]  exponent_t;
  typedef logic [WIDE_W-1:0] wide_t;

  localparam wide_t PRIME    = WIDE_W'(998244353);
  localparam wide_t PRIME_X2 = WIDE_W'(2 * 998244353);

endpackage

`default_nettype wire

>>> hw/rtl/mexp_if.sv
// ----------------------------------------------------------------------------
// Modular exponentiation stream interfaces
// Valid/ready channels for operand items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface mexp_in_if;
  logic                 valid;
  logic                 ready;
  mexp_pkg::residue_t   base;
  mexp_pkg::exponent_t  exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface mexp_out_if;
  logic                 valid;
  logic                 ready;
  mexp_pkg::residue_t   power;

  modport source (output valid, output power, input ready);
  modport sink   (input valid, input power, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mexp_mul.sv
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Interleaved multiply and reduce, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modular_exponentiation_macros.svh"

module mexp_mul (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire mexp_pkg::residue_t a,
  input  wire mexp_pkg::residue_t b,
  output logic                    done,
  output mexp_pkg::residue_t      prod
);
  import mexp_pkg::*;

  residue_t             a_r, a_nxt;
  residue_t             b_r, b_nxt;
  residue_t             acc_r, acc_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  wide_t                sum;
  wide_t                red;

  // Doubling the partial result and adding the multiplicand stays below
  // three times the prime, so at most two subtractions bring it back.
  always_comb begin
    sum = {1'b0, acc_r, 1'b0} + (b_r[RES_W-1] ? {2'b00, a_r} : '0);
    if (sum >= PRIME_X2) begin
      red = sum - PRIME_X2;
    end else if (sum >= PRIME) begin
      red = sum - PRIME;
    end else begin
      red = sum;
    end
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = '0;
      cnt_nxt  = MUL_CNT_W'(MUL_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = red[RES_W-1:0];
      b_nxt   = {b_r[RES_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == MUL_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

  `MEXP_ASSERT(a_mul_prod_reduced, done_r |-> ({2'b00, acc_r} < PRIME), "product not reduced")
  `MEXP_ASSERT(a_mul_busy_count, busy_r |-> (cnt_r != '0), "busy with zero step count")
  `MEXP_NEVER(a_mul_restart_busy, start && busy_r, "multiplier restarted while busy")

endmodule

`default_nettype wire

>>> hw/rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation modulo 998244353
// Right-to-left square-and-multiply over two bit-serial modular multipliers.
// ----------------------------------------------------------------------------
// Each of the 32 scanned exponent bits passes through a start state, 30 serial
// multiply steps and a wait state that takes the products; the result then
// moves into the output register. A new item is taken only once the
// sequencer is idle again; a result that is not taken holds the sequencer
// until the register frees.
// Reset (synchronous, active low) returns the sequencer to idle, empty output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modular_exponentiation_macros.svh"

module modular_exponentiation (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mexp_in_if.sink    in_if,
  mexp_out_if.source out_if
);
  import mexp_pkg::*;

  // One-hot sequencer states.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_WAIT  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  residue_t             acc_r, acc_nxt;
  residue_t             sq_r, sq_nxt;
  logic [SCAN_BITS-1:0] exp_r, exp_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  residue_t             out_power_r, out_power_nxt;

  logic     in_fire;
  logic     out_fire;
  logic     mul_start;
  logic     done_acc;
  logic     done_sq;
  residue_t prod_acc;
  residue_t prod_sq;
  wide_t    base_ext;
  residue_t base_red;

  // Input is only taken when the sequencer is idle; the output register is
  // separate, so a pending result does not hold off the next transfer.
  assign in_if.ready = (state_r == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign out_fire    = out_if.valid && out_if.ready;

  // The base field can exceed the prime by less than one prime, so a single
  // conditional subtraction reduces it.
  always_comb begin
    base_ext = {2'b00, in_if.base};
    if (base_ext >= PRIME) begin
      base_red = RES_W'(base_ext - PRIME);
    end else begin
      base_red = in_if.base;
    end
  end

  // Both multipliers start together: one forms result times square, the
  // other squares the running square. The product into the result is kept
  // only when the current exponent bit is set.
  assign mul_start = (state_r == S_START);

  mexp_mul u_mul_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (acc_r),
    .b     (sq_r),
    .done  (done_acc),
    .prod  (prod_acc)
  );

  mexp_mul u_mul_sq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (sq_r),
    .b     (sq_r),
    .done  (done_sq),
    .prod  (prod_sq)
  );

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    exp_nxt       = exp_r;
    bit_cnt_nxt   = bit_cnt_r;
    out_valid_nxt = out_valid_r;
    out_power_nxt = out_power_r;

    // A result leaves once the sink takes the transfer.
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          acc_nxt     = RES_W'(1);
          sq_nxt      = base_red;
          exp_nxt     = in_if.exponent[SCAN_BITS-1:0];
          bit_cnt_nxt = BIT_CNT_W'(SCAN_BITS);
          state_nxt   = S_START;
        end
      end
      S_START: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (done_acc && done_sq) begin
          if (exp_r[0]) begin
            acc_nxt = prod_acc;
          end
          sq_nxt      = prod_sq;
          exp_nxt     = exp_r >> 1;
          bit_cnt_nxt = bit_cnt_r - 1'b1;
          if (bit_cnt_r == BIT_CNT_W'(1)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_START;
          end
        end
      end
      S_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_power_nxt = acc_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    sq_r        <= sq_nxt;
    exp_r       <= exp_nxt;
    out_power_r <= out_power_nxt;
  end

  assign out_if.valid = out_valid_r;
  assign out_if.power = out_power_r;

  `MEXP_ASSERT(a_top_power_reduced, out_valid_r |-> ({2'b00, out_power_r} < PRIME), "result not reduced")
  `MEXP_ASSERT(a_top_accept_starts, in_fire |=> (state_r == S_START), "accepted item did not start")
  `MEXP_NEVER(a_top_mul_sync, done_acc != done_sq, "multipliers out of step")

endmodule

`default_nettype wire

>>> tb/sv/modular_exponentiation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Sends base/exponent pairs into the block and compares every returned power
// with a hand-entered value or a square-and-multiply predictor. A typed-in table comes first, then
// random operands under changing sender and receiver idling.
// ----------------------------------------------------------------------------

module modular_exponentiation_tb;
  import mexp_pkg::*;

  // Every item runs the whole exponent scan in the block, so the run is long. The
  // limit allows several times the slowest correct run, sender gaps included.
  localparam int              PHASE_ITEMS  = 650;
  localparam int              DRAIN_CYCLES = 1200;
  localparam longint unsigned CYCLE_LIMIT  = 10_000_000;
  localparam int              MAX_REPORTS  = 10;

  // The prime taken from the package, widened for 60-bit products.
  localparam longint unsigned MODULUS = PRIME;

  // One row of the directed table. When has_literal is set, the power was
  // read off by hand. Otherwise the predictor supplies it.
  typedef struct packed {
    residue_t  base;
    exponent_t exponent;
    bit        has_literal;
    residue_t  power;
  } operand_row_t;

  localparam int DIRECTED_COUNT = 23;

  localparam operand_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // A zero exponent gives 1, also when the base is zero.
    '{30'd0,          32'd0,           1'b1, 30'd1},
    // A zero base with a nonzero exponent gives 0.
    '{30'd0,          32'd1,           1'b1, 30'd0},
    '{30'd0,          32'hFFFF_FFFF,   1'b1, 30'd0},
    '{30'd1,          32'hFFFF_FFFF,   1'b1, 30'd1},
    '{30'd12345,      32'd0,           1'b1, 30'd1},
    '{30'd998244352,  32'd0,           1'b1, 30'd1},
    // The largest residue is -1 modulo the prime, so its powers alternate.
    '{30'd998244352,  32'd1,           1'b1, 30'd998244352},
    '{30'd998244352,  32'd2,           1'b1, 30'd1},
    '{30'd998244352,  32'hFFFF_FFFF,   1'b1, 30'd998244352},
    '{30'd2,          32'd29,          1'b1, 30'd536870912},
    '{30'd3,          32'd1,           1'b1, 30'd3},
    // Bases at or above the prime are reduced before use.
    '{30'h3FFF_FFFF,  32'd0,           1'b1, 30'd1},
    '{30'h3FFF_FFFF,  32'd1,           1'b1, 30'd75497470},
    '{30'd998244353,  32'd1,           1'b1, 30'd0},
    '{30'd998244353,  32'd0,           1'b1, 30'd1},
    '{30'd998244354,  32'hFFFF_FFFF,   1'b1, 30'd1},
    // Fermat: any nonzero residue to the power p-1 is 1.
    '{30'd12345,      32'd998244352,   1'b1, 30'd1},
    '{30'd3,          32'h8000_0000,   1'b0, 30'd0},
    '{30'h3FFF_FFFF,  32'hFFFF_FFFF,   1'b0, 30'd0},
    '{30'd123456789,  32'h5555_5555,   1'b0, 30'd0},
    '{30'd998244351,  32'hAAAA_AAAA,   1'b0, 30'd0},
    '{30'd31,         32'h1234_5678,   1'b0, 30'd0},
    '{30'd2,          32'h0000_FFFF,   1'b0, 30'd0}
  };

  logic clk;
  logic rst_n;

  mexp_in_if  in_if ();
  mexp_out_if out_if ();

  modular_exponentiation dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // Powers still owed by the block, oldest first.
  residue_t        expected_powers [$];
  int              failures;
  longint unsigned cycle_count;

  // Idle rates in percent. The driver changes them between phases and the
  // receiver process picks up the new value on its next cycle.
  int sender_idle_pct;
  int receiver_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Right-to-left square-and-multiply. The exponent is scanned over
  // EXP_WIDTH bits, so any bits above that width are dropped first.
  function automatic residue_t predict_power(residue_t base, exponent_t exponent);
    longint unsigned square;
    longint unsigned acc;
    longint unsigned bits;
    int              i;
    square = base;
    square = square % MODULUS;
    acc    = 1;
    bits   = exponent;
    if (EXP_WIDTH < 64) begin
      bits = bits & ((64'd1 << EXP_WIDTH) - 64'd1);
    end
    for (i = 0; i < EXP_WIDTH && i < 64; i++) begin
      if (bits[i]) begin
        acc = (acc * square) % MODULUS;
      end
      square = (square * square) % MODULUS;
    end
    return residue_t'(acc);
  endfunction

  // Most bases are plain residues. Some are tiny, some sit just below the
  // prime, and some lie at or above it so that the reduction is exercised.
  function automatic residue_t random_base();
    case ($urandom_range(9))
      0: return residue_t'($urandom_range(3));
      1: return residue_t'($urandom_range(32'h3FFF_FFFF, 32'(MODULUS)));
      2: return residue_t'(MODULUS - 1 - $urandom_range(3));
      default: return residue_t'($urandom_range(32'(MODULUS - 1)));
    endcase
  endfunction

  // Full-width exponents dominate. Zero, short, single-bit and near-maximum
  // exponents are mixed in to hit the edges of the bit scan.
  function automatic exponent_t random_exponent();
    case ($urandom_range(9))
      0: return '0;
      1: return exponent_t'($urandom_range(64));
      2: return exponent_t'(32'd1 << $urandom_range(31));
      3: return 32'hFFFF_FFFF - exponent_t'($urandom_range(15));
      default: return exponent_t'($urandom);
    endcase
  endfunction

  // Only the first few failures are printed. All of them are counted.
  task automatic note_failure(string msg);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  task automatic check_power(residue_t got);
    residue_t want;
    if (expected_powers.size() == 0) begin
      note_failure($sformatf("result 0x%08h with no item outstanding", got));
    end else begin
      want = expected_powers.pop_front();
      if (got !== want) begin
        note_failure($sformatf("power mismatch: expected %0d, got %0d", want, got));
      end
    end
  endtask

  // One transfer on the operand channel. This task is entered just after a
  // rising edge. Valid is lowered only while idling, so back-to-back items
  // keep it high without a second assignment in the same step. The handshake
  // is judged at the falling edge, where ready and our payload have settled
  // to the values that the next rising edge will see.
  task automatic transfer_operands(residue_t base, exponent_t exponent, residue_t power);
    bit taken;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.base     <= base;
    in_if.exponent <= exponent;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_if.ready;
      if (taken) begin
        expected_powers.push_back(power);
      end
      @(posedge clk);
    end
  endtask

  // The sender stops and waits until the block has returned every result.
  // Valid is only touched when a clock edge follows, so the next transfer
  // never assigns it a second time in the same step.
  task automatic hold_until_empty();
    while (expected_powers.size() != 0) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // The receiver picks a new ready each cycle and checks any transfer at the
  // falling edge before the edge that completes it.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
      @(negedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        check_power(out_if.power);
      end
    end
  end

  // A stuck block ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** modular_exponentiation: FAILED **");
      $finish;
    end
  end

  initial begin
    residue_t  base;
    exponent_t exponent;
    int        phase;
    int        n;

    failures          = 0;
    cycle_count       = 0;
    sender_idle_pct   = 22;
    receiver_idle_pct = 67;
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.base     <= '0;
    in_if.exponent <= '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The directed table runs under the first idling profile.
    foreach (DIRECTED_ROWS[i]) begin
      transfer_operands(DIRECTED_ROWS[i].base, DIRECTED_ROWS[i].exponent,
                        DIRECTED_ROWS[i].has_literal ? DIRECTED_ROWS[i].power :
                        predict_power(DIRECTED_ROWS[i].base, DIRECTED_ROWS[i].exponent));
    end
    hold_until_empty();

    // Phase 0 has a slow receiver, phase 1 a slow sender, and phase 2 has no
    // idling on either side. Now and then the sender also lets the block
    // run dry, so that an item arrives at a fully idle block.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct   = 22;
          receiver_idle_pct = 67;
        end
        1: begin
          sender_idle_pct   = 67;
          receiver_idle_pct = 22;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) == 0) begin
          hold_until_empty();
        end
        base     = random_base();
        exponent = random_exponent();
        transfer_operands(base, exponent, predict_power(base, exponent));
      end
      hold_until_empty();
    end

    // Leave time for any stray result to show up after the last one.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_powers.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_powers.size()));
    end
    if (failures == 0) begin
      $display("** modular_exponentiation: PASSED **");
    end else begin
      $display("** modular_exponentiation: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_if.sv
hw/rtl/mexp_mul.sv
hw/rtl/modular_exponentiation.sv
tb/sv/modular_exponentiation_tb.sv
